// ===== hw/rtl/bds_pkg.sv =====
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants for the 2x2 box-filter downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

   // Geometry limits
   localparam int MAX_WIDTH    = 4096;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int MAX_CH       = 4;
   localparam int LINE_DEPTH   = MAX_WIDTH / 2;

   // Field widths
   localparam int DIM_W    = 13;                  // width/height registers
   localparam int POS_W    = $clog2(MAX_WIDTH);   // column/row position
   localparam int COL_W    = $clog2(LINE_DEPTH);  // output column / line address
   localparam int CH_CNT_W = 3;                   // channel count register
   localparam int NUM_CH   = 4;                   // channel lanes on the ports
   localparam int PIX_W    = 8;
   localparam int PSUM_W   = PIX_W + 1;           // sum of two samples
   localparam int SUM_W    = PIX_W + 2;           // sum of four samples
   localparam int SHIFT_W  = 2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_CHANNELS = 2'd2;

   typedef logic [NUM_CH-1:0][PIX_W-1:0]  pix_vec_type;
   typedef logic [NUM_CH-1:0][PSUM_W-1:0] psum_vec_type;
   typedef logic [NUM_CH-1:0]             chan_mask_type;

   // Per-item decode from the position counters
   typedef struct packed {
      logic                wide;       // source width above one
      logic                hold;       // even column: park the pixel
      logic                emit;       // item completes an output pixel
      logic                wr_line;    // even row: store the pair sum
      logic                rd_line;    // odd row: fetch the stored pair sum
      logic [COL_W-1:0]    col;        // output column
      logic [SHIFT_W-1:0]  shift;      // log2 of the sample count
      logic                frame_last;
   } decode_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bds_ctrl.sv =====
// ----------------------------------------------------------------------------
// bds_ctrl
// Configuration registers, source position counters and per-item decode.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [bds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bds_pkg::DIM_W-1:0]       csr_wdata,
   input  wire logic                            advance,
   output      bds_pkg::decode_type             dec,
   output      bds_pkg::chan_mask_type          chan_mask
);
   import bds_pkg::*;

   logic [DIM_W-1:0]    width_ff,  width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [CH_CNT_W-1:0] nch_ff,    nch_in;
   logic [POS_W-1:0]    col_ff,    col_in;
   logic [POS_W-1:0]    row_ff,    row_in;

   logic [DIM_W-1:0]    wdim_clamped;
   logic [DIM_W-1:0]    hdim_clamped;
   logic [CH_CNT_W-1:0] nch_clamped;
   logic [DIM_W-1:0]    col_next;
   logic [DIM_W-1:0]    row_next;

   logic                w_one, h_one;
   logic                drop_col, drop_row, keep, hdone;
   logic [POS_W-1:0]    half_w_m1, half_h_m1;
   logic [COL_W-1:0]    orow;

   // Clamp written dimensions and channel count
   always_comb begin
      if (csr_wdata == '0) begin
         wdim_clamped = DIM_W'(1);
         hdim_clamped = DIM_W'(1);
      end else begin
         wdim_clamped = (csr_wdata > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : csr_wdata;
         hdim_clamped = (csr_wdata > DIM_W'(HEIGHT_LIMIT)) ? DIM_W'(HEIGHT_LIMIT) : csr_wdata;
      end
      if (csr_wdata[CH_CNT_W-1:0] == '0) begin
         nch_clamped = CH_CNT_W'(1);
      end else if (csr_wdata[CH_CNT_W-1:0] > CH_CNT_W'(MAX_CH)) begin
         nch_clamped = CH_CNT_W'(MAX_CH);
      end else begin
         nch_clamped = csr_wdata[CH_CNT_W-1:0];
      end
   end

   // Advance the raster position, restart it on a dimension write
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      nch_in    = nch_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      col_next  = DIM_W'(col_ff) + DIM_W'(1);
      row_next  = DIM_W'(row_ff) + DIM_W'(1);
      if (csr_wr_en) begin
         case (csr_index)
            REG_SRC_WIDTH: begin
               width_in = wdim_clamped;
               col_in   = '0;
               row_in   = '0;
            end
            REG_SRC_HEIGHT: begin
               height_in = hdim_clamped;
               col_in    = '0;
               row_in    = '0;
            end
            REG_NUM_CHANNELS: begin
               nch_in = nch_clamped;
            end
            default: begin
            end
         endcase
      end else if (advance) begin
         if (col_next >= width_ff) begin
            col_in = '0;
            row_in = (row_next >= height_ff) ? '0 : row_next[POS_W-1:0];
         end else begin
            col_in = col_next[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         nch_ff    <= CH_CNT_W'(MAX_CH);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         nch_ff    <= nch_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // Decode what the current item does
   always_comb begin
      w_one     = (width_ff == DIM_W'(1));
      h_one     = (height_ff == DIM_W'(1));
      drop_col  = !w_one && width_ff[0] && (DIM_W'(col_ff) == width_ff - DIM_W'(1));
      drop_row  = !h_one && height_ff[0] && (DIM_W'(row_ff) == height_ff - DIM_W'(1));
      keep      = !drop_col && !drop_row;
      hdone     = keep && (w_one || col_ff[0]);
      half_w_m1 = w_one ? '0 : (width_ff[DIM_W-1:1] - POS_W'(1));
      half_h_m1 = h_one ? '0 : (height_ff[DIM_W-1:1] - POS_W'(1));
      orow      = h_one ? '0 : row_ff[POS_W-1:1];

      dec.wide    = !w_one;
      dec.hold    = keep && !w_one && !col_ff[0];
      dec.emit    = hdone && (h_one || row_ff[0]);
      dec.wr_line = hdone && !h_one && !row_ff[0];
      dec.rd_line = hdone && !h_one && row_ff[0];
      dec.col     = w_one ? '0 : col_ff[POS_W-1:1];
      if (h_one) begin
         dec.shift = w_one ? SHIFT_W'(0) : SHIFT_W'(1);
      end else begin
         dec.shift = w_one ? SHIFT_W'(1) : SHIFT_W'(2);
      end
      dec.frame_last = (dec.col == half_w_m1[COL_W-1:0]) && (orow == half_h_m1[COL_W-1:0]);
   end

   // Enable channel lanes below the configured count
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         chan_mask[k] = (CH_CNT_W'(k) < nch_ff);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bds_line_store.sv =====
// ----------------------------------------------------------------------------
// bds_line_store
// Line memory of per-column pair sums: one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_line_store (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [bds_pkg::COL_W-1:0]    wr_addr,
   input  wire bds_pkg::psum_vec_type        wr_data,
   input  wire logic                         rd_en,
   input  wire logic [bds_pkg::COL_W-1:0]    rd_addr,
   output      bds_pkg::psum_vec_type        rd_data
);
   import bds_pkg::*;

   psum_vec_type line_mem [LINE_DEPTH];
   psum_vec_type rd_data_ff;

   // Store even-row pair sums
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Fetch for the odd row; hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bds_out.sv =====
// ----------------------------------------------------------------------------
// bds_out
// Vertical add, rounding divide by shift, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_out (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire bds_pkg::psum_vec_type         hsum,
   input  wire logic                          use_line,
   input  wire logic [bds_pkg::SHIFT_W-1:0]   shift,
   input  wire logic                          frame_last,
   input  wire bds_pkg::chan_mask_type        chan_mask,
   input  wire bds_pkg::psum_vec_type         line_data,
   output      logic                          stage_ready,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      bds_pkg::pix_vec_type          rsp_pix,
   output      logic                          rsp_frame_last
);
   import bds_pkg::*;

   logic                s1_vld_ff,  s1_vld_in;
   psum_vec_type        s1_hsum_ff;
   logic                s1_line_ff;
   logic [SHIFT_W-1:0]  s1_shift_ff;
   logic                s1_last_ff;
   chan_mask_type       s1_mask_ff;

   logic                out_vld_ff, out_vld_in;
   pix_vec_type         out_pix_ff;
   logic                out_last_ff;

   logic                out_free;
   logic                s1_move;
   pix_vec_type         rounded;

   assign out_free    = !out_vld_ff || rsp_ready;
   assign s1_move     = s1_vld_ff && out_free;
   assign stage_ready = !s1_vld_ff || out_free;

   // Stage one: hold the item until the result register frees up
   always_comb begin
      if (load) begin
         s1_vld_in = 1'b1;
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_hsum_ff  <= hsum;
         s1_line_ff  <= use_line;
         s1_shift_ff <= shift;
         s1_last_ff  <= frame_last;
         s1_mask_ff  <= chan_mask;
      end
   end

   // Add the stored pair sum, round and divide by the sample count
   always_comb begin
      logic [SUM_W-1:0] total;
      logic [SUM_W-1:0] biased;
      logic [SUM_W-1:0] scaled;
      for (int k = 0; k < NUM_CH; k++) begin
         total = SUM_W'(s1_hsum_ff[k]) + (s1_line_ff ? SUM_W'(line_data[k]) : '0);
         case (s1_shift_ff)
            SHIFT_W'(0): begin
               biased = total;
               scaled = total;
            end
            SHIFT_W'(1): begin
               biased = total + SUM_W'(1);
               scaled = biased >> 1;
            end
            default: begin
               biased = total + SUM_W'(2);
               scaled = biased >> 2;
            end
         endcase
         rounded[k] = s1_mask_ff[k] ? scaled[PIX_W-1:0] : '0;
      end
   end

   // Result register
   always_comb begin
      if (s1_move) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_pix_ff  <= rounded;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_pix        = out_pix_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/box_downsample_2x2_u8_top.sv =====
// ----------------------------------------------------------------------------
// box_downsample_2x2_u8_top
// 2x2 box-filter downsampler for 8-bit pixels of up to four channels.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    req_in_ch0..req_in_ch3
//   rsp_      out        rsp_valid/rsp_ready    rsp_out_ch0..3, rsp_frame_last
//   csr_      in         csr_wr_en              csr_index, csr_wdata
//
// One source pixel is taken per cycle while req_ready is high. The pixel that
// completes a 2x2 block is registered in stage one, alongside the line store
// read, and the result then moves on to the result register when it is free.
// Reset clears the position, registers and pipeline valids; the line store
// is not cleared, each entry is written on an even row before it is read.
// A low rsp_ready holds the result and backs up into req_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_2x2_u8_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [bds_pkg::PIX_W-1:0]       req_in_ch0,
   input  wire logic [bds_pkg::PIX_W-1:0]       req_in_ch1,
   input  wire logic [bds_pkg::PIX_W-1:0]       req_in_ch2,
   input  wire logic [bds_pkg::PIX_W-1:0]       req_in_ch3,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [bds_pkg::PIX_W-1:0]       rsp_out_ch0,
   output      logic [bds_pkg::PIX_W-1:0]       rsp_out_ch1,
   output      logic [bds_pkg::PIX_W-1:0]       rsp_out_ch2,
   output      logic [bds_pkg::PIX_W-1:0]       rsp_out_ch3,
   output      logic                            rsp_frame_last,
   input  wire logic                            csr_wr_en,
   input  wire logic [bds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bds_pkg::DIM_W-1:0]       csr_wdata
);
   import bds_pkg::*;

   decode_type     dec;
   chan_mask_type  chan_mask;
   logic           accept;
   logic           stage_ready;
   pix_vec_type    px;
   pix_vec_type    held_ff, held_in;
   psum_vec_type   hsum;
   psum_vec_type   line_data;
   pix_vec_type    rsp_pix;

   assign req_ready = stage_ready;
   assign accept    = req_valid && stage_ready;

   bds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .dec       (dec),
      .chan_mask (chan_mask)
   );

   // Drop samples of unused channels
   always_comb begin
      px[0] = chan_mask[0] ? req_in_ch0 : '0;
      px[1] = chan_mask[1] ? req_in_ch1 : '0;
      px[2] = chan_mask[2] ? req_in_ch2 : '0;
      px[3] = chan_mask[3] ? req_in_ch3 : '0;
   end

   // Park the even-column pixel for its partner
   assign held_in = (accept && dec.hold) ? px : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // Horizontal pair sum
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         hsum[k] = dec.wide ? (PSUM_W'(held_ff[k]) + PSUM_W'(px[k])) : PSUM_W'(px[k]);
      end
   end

   bds_line_store u_line (
      .clock   (clock),
      .wr_en   (accept && dec.wr_line),
      .wr_addr (dec.col),
      .wr_data (hsum),
      .rd_en   (accept && dec.rd_line),
      .rd_addr (dec.col),
      .rd_data (line_data)
   );

   bds_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (accept && dec.emit),
      .hsum           (hsum),
      .use_line       (dec.rd_line),
      .shift          (dec.shift),
      .frame_last     (dec.frame_last),
      .chan_mask      (chan_mask),
      .line_data      (line_data),
      .stage_ready    (stage_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pix        (rsp_pix),
      .rsp_frame_last (rsp_frame_last)
   );

   assign rsp_out_ch0 = rsp_pix[0];
   assign rsp_out_ch1 = rsp_pix[1];
   assign rsp_out_ch2 = rsp_pix[2];
   assign rsp_out_ch3 = rsp_pix[3];

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x2 box-filter downsampler. Source pixels are
// fed through a valid/ready driver with bursts and gaps, and the result side
// stalls on its own pattern, with one long hold-off per request. A predictor
// in the bench averages each 2x2 block, tracks frame position and the
// stored row of pair sums, and every result is checked field by field
// against the oldest expected pixel. Directed frames cover the geometry and
// channel corner cases. Random frames of small sizes follow, then the
// opening stretch of a frame at the largest width and of one at the
// largest height.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bds_pkg::*;

   localparam int          RANDOM_ITEMS = 800;
   localparam int          WIDE_ITEMS   = 200;
   localparam int          TALL_ITEMS   = 120;
   localparam int          LONG_HOLD    = 400;
   localparam int          SETTLE       = 6;
   localparam int          PRINT_CAP    = 100;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;

   // Index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 2'd3;

   typedef struct packed {
      pix_vec_type ch;
      logic        last;
   } out_pixel_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_QUARTER,
      READY_MOSTLY
   } ready_mode_type;

   // DUT ports, all inputs known from time zero
   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_in_ch0     = '0;
   logic [PIX_W-1:0]     req_in_ch1     = '0;
   logic [PIX_W-1:0]     req_in_ch2     = '0;
   logic [PIX_W-1:0]     req_in_ch3     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [PIX_W-1:0]     rsp_out_ch0;
   logic [PIX_W-1:0]     rsp_out_ch1;
   logic [PIX_W-1:0]     rsp_out_ch2;
   logic [PIX_W-1:0]     rsp_out_ch3;
   logic                 rsp_frame_last;
   logic                 csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [DIM_W-1:0]     csr_wdata      = '0;

   // Stimulus and expectation stores
   pix_vec_type   source_pixels[$];
   out_pixel_type expected_pixels[$];
   pix_vec_type   offered_pix;

   // Predictor state: registers, position, parked pixel and pair-sum row
   logic [DIM_W-1:0]    src_w_reg = 13'd1;
   logic [DIM_W-1:0]    src_h_reg = 13'd1;
   logic [CH_CNT_W-1:0] ch_reg    = 3'd4;
   int unsigned         cur_col   = 0;
   int unsigned         cur_row   = 0;
   pix_vec_type         parked_pix = '0;
   psum_vec_type        line_sums [LINE_DEPTH];

   // Flow control bookkeeping
   int             burst_left    = 0;
   int             gap_left      = 0;
   int             hold_requests = 0;
   int             holds_served  = 0;
   int             hold_left     = 0;
   int             mode_left     = 0;
   ready_mode_type ready_mode    = READY_ALWAYS;
   int             mismatches    = 0;
   int unsigned    cycle_count   = 0;

   box_downsample_2x2_u8_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_ch0     (req_in_ch0),
      .req_in_ch1     (req_in_ch1),
      .req_in_ch2     (req_in_ch2),
      .req_in_ch3     (req_in_ch3),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_ch0    (rsp_out_ch0),
      .rsp_out_ch1    (rsp_out_ch1),
      .rsp_out_ch2    (rsp_out_ch2),
      .rsp_out_ch3    (rsp_out_ch3),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Map a dimension register to the size in effect
   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] val,
                                             input int unsigned limit);
      if (val == 0) return 1;
      if (val > limit) return limit;
      return val;
   endfunction

   // Advance the frame by one source pixel; return 1 with the averaged
   // output pixel when this pixel completes a block
   function automatic bit downsample_pixel(input pix_vec_type pix,
                                           output out_pixel_type res);
      int unsigned        w, h, nc, half_w, half_h, col, orow, shift, k;
      bit                 skip, paired, emit;
      pix_vec_type        p;
      psum_vec_type       pair;
      logic [3:0][SUM_W-1:0] total;
      logic [SUM_W-1:0]   rounded;
      w      = clamp_dim(src_w_reg, MAX_WIDTH);
      h      = clamp_dim(src_h_reg, HEIGHT_LIMIT);
      nc     = (ch_reg == 0) ? 1 : ((ch_reg > MAX_CH) ? MAX_CH : ch_reg);
      half_w = (w >= 2) ? w / 2 : 1;
      half_h = (h >= 2) ? h / 2 : 1;
      res    = '0;
      pair   = '0;
      total  = '0;
      paired = 1'b0;
      emit   = 1'b0;
      col    = 0;
      orow   = 0;
      shift  = 0;
      // zero the lanes beyond the channel count
      for (k = 0; k < NUM_CH; k++)
         p[k] = (k < nc) ? pix[k] : '0;
      // drop a trailing odd column or row
      skip = (w >= 2 && (w % 2) == 1 && cur_col == w - 1) ||
             (h >= 2 && (h % 2) == 1 && cur_row == h - 1);
      if (!skip) begin
         if (w == 1) begin
            for (k = 0; k < NUM_CH; k++) pair[k] = {1'b0, p[k]};
            paired = 1'b1;
         end else if ((cur_col % 2) == 0) begin
            parked_pix = p;
         end else begin
            for (k = 0; k < NUM_CH; k++) pair[k] = {1'b0, parked_pix[k]} + p[k];
            paired = 1'b1;
         end
      end
      // combine horizontally paired sums across the row pair
      if (paired) begin
         col = (w == 1) ? 0 : cur_col / 2;
         if (h == 1) begin
            for (k = 0; k < NUM_CH; k++) total[k] = {1'b0, pair[k]};
            shift = (w == 1) ? 0 : 1;
            emit  = 1'b1;
         end else if ((cur_row % 2) == 0) begin
            line_sums[col] = pair;
         end else begin
            for (k = 0; k < NUM_CH; k++) total[k] = {1'b0, line_sums[col][k]} + pair[k];
            shift = ((w == 1) ? 0 : 1) + 1;
            orow  = cur_row / 2;
            emit  = 1'b1;
         end
      end
      // round to nearest with half up
      if (emit) begin
         for (k = 0; k < NUM_CH; k++) begin
            if (k < nc) begin
               rounded   = SUM_W'((total[k] + ((1 << shift) >> 1)) >> shift);
               res.ch[k] = rounded[PIX_W-1:0];
            end
         end
         res.last = (col == half_w - 1) && (orow == half_h - 1);
      end
      // step the raster position, wrapping at frame end
      cur_col++;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= h) cur_row = 0;
      end
      return emit;
   endfunction

   task automatic report_mismatch(input string what, input logic [PIX_W-1:0] want,
                                  input logic [PIX_W-1:0] got);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // Write one register and mirror it in the predictor
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_SRC_WIDTH: begin
            src_w_reg = val;
            cur_col   = 0;
            cur_row   = 0;
         end
         REG_SRC_HEIGHT: begin
            src_h_reg = val;
            cur_col   = 0;
            cur_row   = 0;
         end
         REG_NUM_CHANNELS: ch_reg = val[CH_CNT_W-1:0];
         default: ;
      endcase
   endtask

   // Wait until every item is taken and every result is back, then settle
   task automatic wait_idle();
      do @(negedge clock);
      while (source_pixels.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic queue_pixels(input int count);
      pix_vec_type p;
      int          i;
      for (i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0:       p = '0;
            1:       p = '1;
            default: p = $urandom;
         endcase
         source_pixels.push_back(p);
      end
   endtask

   // Mostly small sizes, now and then a zero
   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 19))
         0:                 return '0;
         1, 2, 3, 4:        return DIM_W'($urandom_range(9, 24));
         default:           return DIM_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Stimulus sequence
   initial begin
      int          random_left;
      int          n;
      int unsigned frame;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: single-pixel frames pass straight through
      @(negedge clock);
      source_pixels.push_back(32'h0000_0000);
      source_pixels.push_back(32'hFFFF_FFFF);
      source_pixels.push_back(32'hAA55_AA55);
      source_pixels.push_back(32'h55AA_55AA);

      // zero width and zero channel count, two rows of one column
      wait_idle();
      write_reg(REG_SRC_WIDTH, 13'd0);
      write_reg(REG_SRC_HEIGHT, 13'd2);
      write_reg(REG_NUM_CHANNELS, 13'd0);
      @(negedge clock);
      source_pixels.push_back(32'hABCD_EF01);
      source_pixels.push_back(32'h1234_5602);
      source_pixels.push_back(32'h1234_56FF);
      source_pixels.push_back(32'hFEDC_BAFE);

      // odd width on a single row, write to an unused index
      wait_idle();
      write_reg(REG_NONE, 13'h1FFF);
      write_reg(REG_SRC_WIDTH, 13'd3);
      write_reg(REG_SRC_HEIGHT, 13'd1);
      write_reg(REG_NUM_CHANNELS, 13'd2);
      @(negedge clock);
      source_pixels.push_back(32'h7700_FF01);
      source_pixels.push_back(32'h8800_FF00);
      source_pixels.push_back(32'h9999_9999);

      // odd width and height, channel count saturated, then cut to one
      // channel mid-frame and run past the frame end
      wait_idle();
      write_reg(REG_SRC_WIDTH, 13'd5);
      write_reg(REG_SRC_HEIGHT, 13'd3);
      write_reg(REG_NUM_CHANNELS, 13'd7);
      @(negedge clock);
      queue_pixels(8);
      wait_idle();
      write_reg(REG_NUM_CHANNELS, 13'h1FF9);
      @(negedge clock);
      queue_pixels(9);

      // random frames of small sizes, with one long hold-off at the start
      wait_idle();
      hold_requests++;
      random_left = RANDOM_ITEMS;
      while (random_left > 0) begin
         if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_WIDTH, pick_dim());
         if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_HEIGHT, pick_dim());
         if ($urandom_range(0, 2) != 0)
            write_reg(REG_NUM_CHANNELS,
                      DIM_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                         : $urandom_range(0, 7)));
         frame = clamp_dim(src_w_reg, MAX_WIDTH) * clamp_dim(src_h_reg, HEIGHT_LIMIT);
         if ($urandom_range(0, 2) != 0)
            n = frame * $urandom_range(1, 2);
         else
            n = $urandom_range(1, 2 * frame);
         if (n > random_left) n = random_left;
         @(negedge clock);
         queue_pixels(n);
         random_left -= n;
         wait_idle();
      end

      // largest width, saturated from the top of the register range
      hold_requests++;
      write_reg(REG_SRC_WIDTH, 13'h1FFF);
      write_reg(REG_SRC_HEIGHT, 13'd1);
      write_reg(REG_NUM_CHANNELS, 13'd4);
      @(negedge clock);
      queue_pixels(WIDE_ITEMS);
      wait_idle();

      // largest height on a single column
      write_reg(REG_SRC_WIDTH, 13'd1);
      write_reg(REG_SRC_HEIGHT, 13'h1FFF);
      @(negedge clock);
      queue_pixels(TALL_ITEMS);
      wait_idle();

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Source driver: offer items in bursts, hold each until taken
   always @(posedge clock) begin : drive_pixels
      out_pixel_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (downsample_pixel(offered_pix, res)) expected_pixels.push_back(res);
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (source_pixels.size() != 0) begin
               offered_pix = source_pixels.pop_front();
               req_valid  <= 1'b1;
               req_in_ch0 <= offered_pix[0];
               req_in_ch1 <= offered_pix[1];
               req_in_ch2 <= offered_pix[2];
               req_in_ch3 <= offered_pix[3];
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 20);
                  gap_left   = $urandom_range(0, 5);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: check each accepted item, then pick the next ready
   always @(posedge clock) begin : take_results
      out_pixel_type want;
      pix_vec_type   got;
      int            k;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_ch3, rsp_out_ch2, rsp_out_ch1, rsp_out_ch0};
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= PRINT_CAP)
                  $display("%0t ns: unexpected result, expected none, actual %h last %b",
                           $time, got, rsp_frame_last);
            end else begin
               want = expected_pixels.pop_front();
               for (k = 0; k < NUM_CH; k++)
                  if (got[k] !== want.ch[k])
                     report_mismatch($sformatf("out_ch%0d", k), want.ch[k], got[k]);
               if (rsp_frame_last !== want.last)
                  report_mismatch("frame_last", want.last, rsp_frame_last);
            end
         end
         // long hold-off on request, otherwise the current stall pattern
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(10, 80);
            end else begin
               mode_left--;
            end
            case (ready_mode)
               READY_ALWAYS:  rsp_ready <= 1'b1;
               READY_HALF:    rsp_ready <= ($urandom_range(0, 1) == 1);
               READY_QUARTER: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:       rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
hw/rtl/bds_pkg.sv
hw/rtl/bds_ctrl.sv
hw/rtl/bds_line_store.sv
hw/rtl/bds_out.sv
hw/rtl/box_downsample_2x2_u8_top.sv
tb/tb_top.sv
